FILE: rtl/mbrfc_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the modbus rtu response frame checker
// no dependencies; used by mbrfc_crc_byte and modbus_response_frame_checker
package mbrfc_pkg;

  localparam int unsigned BUFFER_BYTES     = 256;
  localparam int unsigned CNT_W            = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned EXP_W            = 9;
  localparam int unsigned CMP_W            = ((CNT_W > EXP_W) ? CNT_W : EXP_W) + 1;
  localparam int unsigned FLEN_W           = 9;
  localparam int unsigned MIN_DECIDE_BYTES = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_EXCEPTION_BIT = 8'h80;
  localparam logic [7:0] FC_READ_COILS    = 8'h01;
  localparam logic [7:0] FC_READ_INPUTS   = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_RG = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
  localparam logic [7:0] FC_WRITE_REG     = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS    = 8'h10;

  localparam logic [EXP_W-1:0] LEN_EXCEPTION = EXP_W'(5);
  localparam logic [EXP_W-1:0] LEN_READ_BASE = EXP_W'(5);
  localparam logic [EXP_W-1:0] LEN_WRITE     = EXP_W'(8);
  localparam logic [EXP_W-1:0] LEN_UNKNOWN   = EXP_W'(0);

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_READY = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

endpackage

FILE: rtl/modbus_response_frame_checker.sv
`timescale 1ns / 1ps
// modbus rtu response frame checker: per-byte status with on-the-fly crc-16
// the input transfer lands in the input register, and its result is then registered in the result register
// throughput: one byte per cycle unless m_axis stalls; the crc byte step and length compares sit in one stage
// reset: frame count 0, crc 0xffff, function code and byte count 0, no result pending
// depends on mbrfc_pkg and mbrfc_crc_byte
module modbus_response_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [1:0] status, [10:2] frame_length, [15:11] zero
);

  localparam int unsigned CNT_W  = mbrfc_pkg::CNT_W;
  localparam int unsigned CMP_W  = mbrfc_pkg::CMP_W;
  localparam int unsigned EXP_W  = mbrfc_pkg::EXP_W;
  localparam int unsigned FLEN_W = mbrfc_pkg::FLEN_W;

  // input register
  logic       in_valid_q;
  logic       in_action_q;
  logic [7:0] in_byte_q;

  // result register
  logic                    out_valid_q;
  mbrfc_pkg::status_e      out_status_q, out_status_d;
  logic [FLEN_W-1:0]       out_len_q, out_len_d;

  // frame state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       fc_q, fc_d;
  logic [7:0]       lf_q, lf_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic             good_q, good_d;

  logic out_adv;
  logic in_adv;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign in_adv        = in_valid_q && out_adv;
  assign s_axis_tready = !in_valid_q || out_adv;

  logic [15:0]      crc_base;
  logic [15:0]      crc_upd;
  logic [EXP_W-1:0] exp_len;
  logic [CMP_W-1:0] idx_w;
  logic [CMP_W-1:0] exp_w;
  logic [CMP_W-1:0] cnt_next_w;

  assign crc_base = (cnt_q == '0) ? mbrfc_pkg::CRC_INIT : crc_q;

  mbrfc_crc_byte u_crc (
    .crc_i  (crc_base),
    .byte_i (in_byte_q),
    .crc_o  (crc_upd)
  );

  // expected frame length from the function code and byte count seen so far
  always_comb begin
    logic [7:0] fc_v;
    logic [7:0] lf_v;
    fc_v = (cnt_q == CNT_W'(1)) ? in_byte_q : fc_q;
    lf_v = (cnt_q == CNT_W'(2)) ? in_byte_q : lf_q;
    if ((fc_v & mbrfc_pkg::FC_EXCEPTION_BIT) != 8'h00) begin
      exp_len = mbrfc_pkg::LEN_EXCEPTION;
    end else if (fc_v == mbrfc_pkg::FC_READ_COILS || fc_v == mbrfc_pkg::FC_READ_INPUTS ||
                 fc_v == mbrfc_pkg::FC_READ_HOLDING || fc_v == mbrfc_pkg::FC_READ_INPUT_RG) begin
      exp_len = mbrfc_pkg::LEN_READ_BASE + EXP_W'(lf_v);
    end else if (fc_v == mbrfc_pkg::FC_WRITE_COIL || fc_v == mbrfc_pkg::FC_WRITE_REG ||
                 fc_v == mbrfc_pkg::FC_WRITE_COILS || fc_v == mbrfc_pkg::FC_WRITE_REGS) begin
      exp_len = mbrfc_pkg::LEN_WRITE;
    end else begin
      exp_len = mbrfc_pkg::LEN_UNKNOWN;
    end
  end

  assign idx_w      = CMP_W'(cnt_q);
  assign exp_w      = CMP_W'(exp_len);
  assign cnt_next_w = idx_w + CMP_W'(1);

  always_comb begin
    cnt_d        = cnt_q;
    fc_d         = fc_q;
    lf_d         = lf_q;
    crc_d        = crc_q;
    crc_lo_d     = crc_lo_q;
    good_d       = good_q;
    out_status_d = mbrfc_pkg::ST_MORE;
    out_len_d    = '0;
    if (in_action_q == mbrfc_pkg::ACT_CLEAR) begin
      cnt_d  = '0;
      good_d = 1'b0;
    end else if (idx_w >= CMP_W'(mbrfc_pkg::BUFFER_BYTES)) begin
      cnt_d        = '0;
      good_d       = 1'b0;
      out_status_d = mbrfc_pkg::ST_ERROR;
    end else begin
      if (cnt_q == '0) begin
        good_d = 1'b0;
      end
      if (cnt_q == CNT_W'(1)) begin
        fc_d = in_byte_q;
      end
      if (cnt_q == CNT_W'(2)) begin
        lf_d = in_byte_q;
      end
      crc_d = crc_base;
      if (idx_w < CMP_W'(3)) begin
        crc_d = crc_upd;
      end else if (exp_len != mbrfc_pkg::LEN_UNKNOWN) begin
        if (idx_w + CMP_W'(2) < exp_w) begin
          crc_d = crc_upd;
        end else if (idx_w + CMP_W'(2) == exp_w) begin
          crc_lo_d = in_byte_q;
        end else if (cnt_next_w == exp_w) begin
          good_d = ({in_byte_q, crc_lo_q} == crc_base);
        end
      end
      cnt_d = CNT_W'(cnt_next_w);
      priority if (cnt_next_w < CMP_W'(mbrfc_pkg::MIN_DECIDE_BYTES)) begin
        out_status_d = mbrfc_pkg::ST_MORE;
      end else if (exp_len == mbrfc_pkg::LEN_UNKNOWN ||
                   exp_w > CMP_W'(mbrfc_pkg::BUFFER_BYTES)) begin
        out_status_d = mbrfc_pkg::ST_ERROR;
      end else if (cnt_next_w < exp_w) begin
        out_status_d = mbrfc_pkg::ST_MORE;
      end else if (good_d) begin
        out_status_d = mbrfc_pkg::ST_READY;
      end else begin
        out_status_d = mbrfc_pkg::ST_ERROR;
      end
      if (out_status_d == mbrfc_pkg::ST_ERROR) begin
        cnt_d  = '0;
        good_d = 1'b0;
      end
    end
    out_len_d = FLEN_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= s_axis_tuser[0];
      in_byte_q   <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      fc_q        <= '0;
      lf_q        <= '0;
      crc_q       <= mbrfc_pkg::CRC_INIT;
      crc_lo_q    <= '0;
      good_q      <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      if (in_adv) begin
        cnt_q    <= cnt_d;
        fc_q     <= fc_d;
        lf_q     <= lf_d;
        crc_q    <= crc_d;
        crc_lo_q <= crc_lo_d;
        good_q   <= good_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_status_q <= out_status_d;
      out_len_q    <= out_len_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_len_q, out_status_q};

endmodule

FILE: rtl/mbrfc_crc_byte.sv
`timescale 1ns / 1ps
// crc-16 (reflected poly 0xa001) update over one byte, eight bit steps unrolled
// depends on mbrfc_pkg for the polynomial
module mbrfc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mbrfc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

FILE: tb/modbus_response_frame_checker_test.sv
`timescale 1ns / 1ps
// self-checking testbench for modbus_response_frame_checker: directed and random response traffic
// predicts status and frame length per transfer and compares in order; uses mbrfc_pkg and modbus_response_frame_checker
module modbus_response_frame_checker_test;

  typedef struct packed {
    mbrfc_pkg::status_e           st;
    logic [mbrfc_pkg::FLEN_W-1:0] len;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic [0:0]  s_axis_tuser = 1'b0;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;          // [1:0] status, [10:2] frame_length, [15:11] zero

  // predictor state
  int unsigned frame_cnt;
  logic [7:0]  func_code;
  logic [7:0]  len_byte;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_rx;
  bit          crc_ok;

  frame_result_t status_due[$];
  frame_result_t want;
  int          error_cnt = 0;
  int          items_sent = 0;
  bit          source_gap_en = 1'b1;
  bit          sink_stall_en = 1'b1;
  int          stall_left = 0;

  modbus_response_frame_checker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ mbrfc_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic bit is_read_code(input logic [7:0] fc);
    return fc inside {mbrfc_pkg::FC_READ_COILS, mbrfc_pkg::FC_READ_INPUTS,
                      mbrfc_pkg::FC_READ_HOLDING, mbrfc_pkg::FC_READ_INPUT_RG};
  endfunction

  // 0 means unknown function code
  function automatic int unsigned frame_len_for(input logic [7:0] fc, input logic [7:0] lf);
    if ((fc & mbrfc_pkg::FC_EXCEPTION_BIT) != 8'h00) return 5;
    if (is_read_code(fc)) return 5 + lf;
    if (fc inside {mbrfc_pkg::FC_WRITE_COIL, mbrfc_pkg::FC_WRITE_REG,
                   mbrfc_pkg::FC_WRITE_COILS, mbrfc_pkg::FC_WRITE_REGS}) return 8;
    return 0;
  endfunction

  task automatic predict_frame_status(input mbrfc_pkg::action_e act, input logic [7:0] b);
    int unsigned idx;
    int unsigned flen;
    frame_result_t r;
    r.st = mbrfc_pkg::ST_MORE;
    if (act == mbrfc_pkg::ACT_CLEAR) begin
      frame_cnt = 0;
      crc_ok = 1'b0;
    end else if (frame_cnt + 1 > mbrfc_pkg::BUFFER_BYTES) begin
      frame_cnt = 0;
      crc_ok = 1'b0;
      r.st = mbrfc_pkg::ST_ERROR;
    end else begin
      idx = frame_cnt;
      if (idx == 0) begin
        crc_acc = mbrfc_pkg::CRC_INIT;
        crc_ok = 1'b0;
      end
      if (idx == 1) func_code = b;
      if (idx == 2) len_byte = b;
      flen = frame_len_for(func_code, len_byte);
      if (idx < 3) begin
        crc_acc = crc16_byte(crc_acc, b);
      end else if (flen != 0) begin
        if (idx + 2 < flen) crc_acc = crc16_byte(crc_acc, b);
        else if (idx + 2 == flen) crc_lo_rx = b;
        else if (idx + 1 == flen) crc_ok = ({b, crc_lo_rx} == crc_acc);
      end
      frame_cnt = idx + 1;
      if (frame_cnt < mbrfc_pkg::MIN_DECIDE_BYTES) begin
        r.st = mbrfc_pkg::ST_MORE;
      end else if (flen == 0 || flen > mbrfc_pkg::BUFFER_BYTES) begin
        r.st = mbrfc_pkg::ST_ERROR;
      end else if (frame_cnt < flen) begin
        r.st = mbrfc_pkg::ST_MORE;
      end else if (crc_ok) begin
        r.st = mbrfc_pkg::ST_READY;
      end else begin
        r.st = mbrfc_pkg::ST_ERROR;
      end
      if (r.st == mbrfc_pkg::ST_ERROR) begin
        frame_cnt = 0;
        crc_ok = 1'b0;
      end
    end
    r.len = frame_cnt[mbrfc_pkg::FLEN_W-1:0];
    status_due.push_back(r);
  endtask

  task automatic send_byte(input mbrfc_pkg::action_e act, input logic [7:0] b);
    int gap;
    if (source_gap_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame_status(act, b);
    items_sent++;
  endtask

  // body: data byte count for reads, ignored otherwise
  task automatic send_frame(input logic [7:0] fc, input int body, input bit bad_crc);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(fc);
    if ((fc & mbrfc_pkg::FC_EXCEPTION_BIT) != 8'h00) begin
      fb.push_back(8'($urandom_range(0, 255)));
    end else if (is_read_code(fc)) begin
      fb.push_back(8'(body));
      repeat (body) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (4) fb.push_back(8'($urandom_range(0, 255)));
    end
    crc = mbrfc_pkg::CRC_INIT;
    foreach (fb[i]) crc = crc16_byte(crc, fb[i]);
    if (bad_crc) crc ^= 16'(1) << $urandom_range(0, 15);
    fb.push_back(crc[7:0]);
    fb.push_back(crc[15:8]);
    foreach (fb[i]) send_byte(mbrfc_pkg::ACT_APPEND, fb[i]);
  endtask

  function automatic logic [7:0] random_code();
    logic [7:0] codes[8] = '{mbrfc_pkg::FC_READ_COILS, mbrfc_pkg::FC_READ_INPUTS,
                             mbrfc_pkg::FC_READ_HOLDING, mbrfc_pkg::FC_READ_INPUT_RG,
                             mbrfc_pkg::FC_WRITE_COIL, mbrfc_pkg::FC_WRITE_REG,
                             mbrfc_pkg::FC_WRITE_COILS, mbrfc_pkg::FC_WRITE_REGS};
    int p;
    p = $urandom_range(0, 19);
    if (p < 16) return codes[p % 8];
    if (p < 18) return mbrfc_pkg::FC_EXCEPTION_BIT | 8'($urandom_range(0, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int random_body();
    int p;
    p = $urandom_range(0, 99);
    if (p < 90) return $urandom_range(0, 16);
    if (p < 98) return $urandom_range(17, mbrfc_pkg::BUFFER_BYTES - 5);
    return $urandom_range(mbrfc_pkg::BUFFER_BYTES - 4, 255);
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_clear_and_unknown();
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'hFF);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h00);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h00);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'hFF);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'hFF);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h11);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h07);
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'h00);
  endtask

  task automatic test_function_codes();
    logic [7:0] codes[10] = '{mbrfc_pkg::FC_READ_COILS, mbrfc_pkg::FC_READ_INPUTS,
                              mbrfc_pkg::FC_READ_HOLDING, mbrfc_pkg::FC_READ_INPUT_RG,
                              mbrfc_pkg::FC_WRITE_COIL, mbrfc_pkg::FC_WRITE_REG,
                              mbrfc_pkg::FC_WRITE_COILS, mbrfc_pkg::FC_WRITE_REGS,
                              mbrfc_pkg::FC_EXCEPTION_BIT, 8'hFF};
    foreach (codes[i]) begin
      send_byte(mbrfc_pkg::ACT_CLEAR, 8'h00);
      send_frame(codes[i], i, 1'b0);
    end
  endtask

  task automatic test_bad_frames();
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'h00);
    send_frame(mbrfc_pkg::FC_WRITE_REGS, 0, 1'b1);
    send_frame(mbrfc_pkg::FC_READ_HOLDING, 2, 1'b1);
    // declared length beyond the buffer
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h01);
    send_byte(mbrfc_pkg::ACT_APPEND, mbrfc_pkg::FC_READ_HOLDING);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'd252);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h00);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'hFF);
    send_byte(mbrfc_pkg::ACT_APPEND, mbrfc_pkg::FC_READ_COILS);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'hFF);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h55);
    // clear in the middle of a frame
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h01);
    send_byte(mbrfc_pkg::ACT_APPEND, mbrfc_pkg::FC_WRITE_REG);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'hAA);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h00);
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'hAA);
  endtask

  task automatic test_buffer_limits();
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'h00);
    send_frame(mbrfc_pkg::FC_READ_INPUT_RG, mbrfc_pkg::BUFFER_BYTES - 5, 1'b0);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'hFF);
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'h00);
    send_frame(8'h83, 0, 1'b0);
    repeat (mbrfc_pkg::BUFFER_BYTES - 5)
      send_byte(mbrfc_pkg::ACT_APPEND, 8'($urandom_range(0, 255)));
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h00);
    send_byte(mbrfc_pkg::ACT_APPEND, 8'h01);
  endtask

  task automatic test_drain_pause();
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'h00);
    send_frame(mbrfc_pkg::FC_WRITE_COIL, 0, 1'b0);
    wait_drained();
    send_byte(mbrfc_pkg::ACT_CLEAR, 8'h00);
    send_frame(mbrfc_pkg::FC_READ_COILS, 3, 1'b0);
  endtask

  task automatic test_random_traffic(input int target);
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 9) != 0)
          send_byte(mbrfc_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
        send_frame(random_code(), random_body(), $urandom_range(0, 5) == 0);
      end else if (pick < 85) begin
        send_byte(mbrfc_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
        send_byte(mbrfc_pkg::ACT_APPEND, 8'($urandom_range(0, 255)));
        send_byte(mbrfc_pkg::ACT_APPEND, random_code());
        repeat ($urandom_range(0, 5))
          send_byte(mbrfc_pkg::ACT_APPEND, 8'($urandom_range(0, 255)));
        send_byte(mbrfc_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(mbrfc_pkg::action_e'($urandom_range(0, 9) == 0),
                    8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_quiet_tail(input int count);
    source_gap_en = 1'b0;
    sink_stall_en = 1'b0;
    test_random_traffic(items_sent + count);
  endtask

  // result sink with bursty back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_due.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected result transfer: status %0d length %0d",
                   m_axis_tdata[1:0], m_axis_tdata[10:2]);
      end else begin
        want = status_due.pop_front();
        if (m_axis_tdata[1:0] !== want.st || m_axis_tdata[10:2] !== want.len) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("mismatch at %0t: status exp %0d got %0d, length exp %0d got %0d",
                     $realtime, want.st, m_axis_tdata[1:0], want.len, m_axis_tdata[10:2]);
        end
      end
    end
  end

  initial begin
    frame_cnt = 0;
    func_code = 8'h00;
    len_byte  = 8'h00;
    crc_acc   = mbrfc_pkg::CRC_INIT;
    crc_lo_rx = 8'h00;
    crc_ok    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_clear_and_unknown();
    test_function_codes();
    test_bad_frames();
    test_buffer_limits();
    test_drain_pause();
    test_random_traffic(items_sent + 600);
    test_quiet_tail(150);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (status_due.size() != 0) error_cnt++;
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
